>>> rtl/ir_remote_frame_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit_macros.svh
// Assertion macros for the IR remote frame encoder, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_FRAME_ENCODER_UNIT_MACROS_SVH
`define IR_REMOTE_FRAME_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, held off during reset
`define IRFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irfe assertion failed");
// next-cycle implication, held off during reset
`define IRFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irfe assertion failed");
`else
`define IRFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IRFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/irfe_pkg.sv
// ----------------------------------------------------------------------------
// irfe_pkg
// Types, constants and the key code table of the IR remote frame encoder
// ----------------------------------------------------------------------------
package irfe_pkg;

  // table and length limits
  localparam int TABLE_DEPTH = 128;
  localparam int LEN_BITS    = 8;
  localparam int TABLE_FILL  = 68;

  localparam logic [7:0] LEN_MASK = 8'(((1 << LEN_BITS) - 1) & 255);

  // segment lengths in carrier periods
  localparam logic [7:0] HEAD_ON_LEN  = 8'd96;
  localparam logic [7:0] HEAD_OFF_LEN = 8'd32;
  localparam logic [7:0] RC6_UNIT     = 8'd16;
  localparam logic [7:0] RC6_DOUBLE   = 8'd32;
  localparam logic [7:0] HALF_3010    = 8'd32;

  // special key codes
  localparam logic [7:0] NO_CODE    = 8'hFF;
  localparam logic [6:0] KEY_3010_A = 7'd16;
  localparam logic [6:0] KEY_3010_B = 7'd57;

  // frame geometry
  localparam int         SREG_BITS    = 37;
  localparam logic [5:0] RC6_SYMS     = 6'd38;
  localparam logic [5:0] T3010_SYMS   = 6'd14;
  localparam logic [5:0] RC6_HEAD_IDX = 6'd0;
  localparam logic [5:0] RC6_TOG_IDX  = 6'd5;

  // configuration register indexes
  localparam logic [2:0] REG_MODE_BITS    = 3'd0;
  localparam logic [2:0] REG_SYSTEM_HIGH  = 3'd1;
  localparam logic [2:0] REG_SYSTEM_LOW   = 3'd2;
  localparam logic [2:0] REG_CONTROL_BYTE = 3'd3;
  localparam logic [2:0] REG_USER_CODE    = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } irfe_state_t;

  // mask a segment length to the length width
  function automatic logic [7:0] len_mask(input logic [7:0] len);
    return len & LEN_MASK;
  endfunction

  // key code lookup, key 1 is the first table entry
  function automatic logic [7:0] key_code(input logic [6:0] key);
    logic [7:0] code;
    case (key)
      7'd16: code = 8'h0C;
      7'd18: code = 8'h83;
      7'd19: code = 8'h0C;
      7'd21: code = 8'h0D;
      7'd22: code = 8'hCC;
      7'd23: code = 8'hF2;
      7'd25: code = 8'h54;
      7'd26: code = 8'h10;
      7'd27: code = 8'h58;
      7'd28: code = 8'h20;
      7'd30: code = 8'h5A;
      7'd31: code = 8'h5C;
      7'd32: code = 8'h5B;
      7'd33: code = 8'h11;
      7'd34: code = 8'h59;
      7'd36: code = 8'h21;
      7'd37: code = 8'hA9;
      7'd38: code = 8'h6D;
      7'd39: code = 8'h6E;
      7'd40: code = 8'h6F;
      7'd41: code = 8'h70;
      7'd43: code = 8'h4B;
      7'd44: code = 8'hD8;
      7'd45: code = 8'hF3;
      7'd46: code = 8'h84;
      7'd47: code = 8'h0F;
      7'd48: code = 8'h29;
      7'd49: code = 8'h30;
      7'd51: code = 8'h28;
      7'd52: code = 8'h37;
      7'd53: code = 8'h2C;
      7'd54: code = 8'h31;
      7'd55: code = 8'h01;
      7'd56: code = 8'h02;
      7'd57: code = 8'h03;
      7'd58: code = 8'h04;
      7'd60: code = 8'h05;
      7'd61: code = 8'h06;
      7'd62: code = 8'h07;
      7'd63: code = 8'h08;
      7'd64: code = 8'h09;
      7'd65: code = 8'h38;
      7'd66: code = 8'h00;
      7'd67: code = 8'hFB;
      default: code = NO_CODE;
    endcase
    // entries past the table depth or the filled part are unused
    if (int'(key) == 0 || int'(key) - 1 >= TABLE_DEPTH || int'(key) - 1 >= TABLE_FILL) begin
      code = NO_CODE;
    end
    return code;
  endfunction

endpackage

>>> rtl/ir_remote_frame_encoder_unit.sv
// A key loads the state and frame shift register, then its first symbol enters the
// output register. One symbol per cycle while the output is not stalled, from a 37-bit
// frame shift register; the symbol counter sets the length, 38 symbols for RC-6, 14 for 3010.
// A new key is taken as soon as the last symbol of a frame is in the output register.
// Reset: control and configuration registers return to their defaults, toggle and previous key are cleared.
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit
// Turns scanned keys into RC-6 mode 6 or 3010 IR frames, one symbol per transaction
// ----------------------------------------------------------------------------
`include "ir_remote_frame_encoder_unit_macros.svh"

module ir_remote_frame_encoder_unit
  import irfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // key channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  in_key_index,
  // symbol channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_first_on,
  output logic [7:0]  out_first_len,
  output logic        out_second_on,
  output logic [7:0]  out_second_len,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [3:0] mode_bits_r;
  logic [7:0] system_high_r;
  logic [7:0] system_low_r;
  logic [7:0] control_byte_r;
  logic [4:0] user_code_r;

  // key state
  logic [6:0] prev_key_r;
  logic       toggle_r;

  // frame sequencer
  irfe_state_t          state_r, state_nxt;
  logic [SREG_BITS-1:0] sreg_r, sreg_nxt;
  logic [5:0]           sym_idx_r, sym_idx_nxt;
  logic [5:0]           frame_len_r, frame_len_nxt;
  logic                 is3010_r, is3010_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic       first_on_r, first_on_nxt;
  logic [7:0] first_len_r, first_len_nxt;
  logic       second_on_r, second_on_nxt;
  logic [7:0] second_len_r, second_len_nxt;
  logic       last_r, last_nxt;

  logic       in_acc;
  logic       emit;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic [7:0] code;
  logic       key_nz;
  logic       key_is3010;
  logic       toggle_nxt;
  logic       bit_cur;
  logic       sym_last;

  // configuration write and read
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_bits_r    <= 4'd6;
      system_high_r  <= 8'h80;
      system_low_r   <= 8'h56;
      control_byte_r <= 8'hA7;
      user_code_r    <= 5'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE_BITS:    mode_bits_r    <= pwdata[3:0];
        REG_SYSTEM_HIGH:  system_high_r  <= pwdata[7:0];
        REG_SYSTEM_LOW:   system_low_r   <= pwdata[7:0];
        REG_CONTROL_BYTE: control_byte_r <= pwdata[7:0];
        REG_USER_CODE:    user_code_r    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE_BITS:    prdata = {28'd0, mode_bits_r};
      REG_SYSTEM_HIGH:  prdata = {24'd0, system_high_r};
      REG_SYSTEM_LOW:   prdata = {24'd0, system_low_r};
      REG_CONTROL_BYTE: prdata = {24'd0, control_byte_r};
      REG_USER_CODE:    prdata = {27'd0, user_code_r};
      default:          prdata = 32'd0;
    endcase
  end

  // key lookup and toggle
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid & ~in_stall;
  assign code       = key_code(in_key_index);
  assign key_nz     = (in_key_index != 7'd0);
  assign key_is3010 = (in_key_index == KEY_3010_A) || (in_key_index == KEY_3010_B);
  assign toggle_nxt = toggle_r ^ (key_nz && (in_key_index != prev_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r <= 7'd0;
      toggle_r   <= 1'b0;
    end else if (in_acc) begin
      prev_key_r <= in_key_index;
      toggle_r   <= toggle_nxt;
    end
  end

  // sequencer: load the frame bits, then one symbol per free output slot
  assign emit     = (state_r == ST_SEND) && (!out_valid_r || !out_stall);
  assign bit_cur  = sreg_r[SREG_BITS-1];
  assign sym_last = (sym_idx_r == frame_len_r - 6'd1);

  always_comb begin
    state_nxt      = state_r;
    sreg_nxt       = sreg_r;
    sym_idx_nxt    = sym_idx_r;
    frame_len_nxt  = frame_len_r;
    is3010_nxt     = is3010_r;
    out_valid_nxt  = out_valid_r & out_stall;
    first_on_nxt   = first_on_r;
    first_len_nxt  = first_len_r;
    second_on_nxt  = second_on_r;
    second_len_nxt = second_len_r;
    last_nxt       = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && key_nz && code != NO_CODE) begin
          state_nxt   = ST_SEND;
          sym_idx_nxt = 6'd0;
          is3010_nxt  = key_is3010;
          if (key_is3010) begin
            frame_len_nxt = T3010_SYMS;
            sreg_nxt = {2'b11, toggle_nxt, user_code_r, code[5:0], 23'd0};
          end else begin
            frame_len_nxt = RC6_SYMS;
            sreg_nxt = {mode_bits_r, toggle_nxt, system_high_r, system_low_r,
                        control_byte_r, code};
          end
        end
      end
      ST_SEND: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          last_nxt      = sym_last;
          sym_idx_nxt   = sym_idx_r + 6'd1;
          // every symbol but the rc-6 head consumes one frame bit
          if (is3010_r || sym_idx_r != RC6_HEAD_IDX) begin
            sreg_nxt = {sreg_r[SREG_BITS-2:0], 1'b0};
          end
          if (is3010_r) begin
            first_on_nxt   = ~bit_cur;
            first_len_nxt  = len_mask(HALF_3010);
            second_on_nxt  = bit_cur;
            second_len_nxt = len_mask(HALF_3010);
          end else if (sym_idx_r == RC6_HEAD_IDX) begin
            first_on_nxt   = 1'b1;
            first_len_nxt  = len_mask(HEAD_ON_LEN);
            second_on_nxt  = 1'b0;
            second_len_nxt = len_mask(HEAD_OFF_LEN);
          end else if (sym_idx_r == RC6_TOG_IDX) begin
            first_on_nxt   = bit_cur;
            first_len_nxt  = len_mask(RC6_DOUBLE);
            second_on_nxt  = ~bit_cur;
            second_len_nxt = len_mask(RC6_DOUBLE);
          end else begin
            first_on_nxt   = bit_cur;
            first_len_nxt  = len_mask(RC6_UNIT);
            second_on_nxt  = ~bit_cur;
            second_len_nxt = len_mask(RC6_UNIT);
          end
          if (sym_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sym_idx_r   <= 6'd0;
      frame_len_r <= RC6_SYMS;
      is3010_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sym_idx_r   <= sym_idx_nxt;
      frame_len_r <= frame_len_nxt;
      is3010_r    <= is3010_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sreg_r       <= sreg_nxt;
    first_on_r   <= first_on_nxt;
    first_len_r  <= first_len_nxt;
    second_on_r  <= second_on_nxt;
    second_len_r <= second_len_nxt;
    last_r       <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_first_on   = first_on_r;
  assign out_first_len  = first_len_r;
  assign out_second_on  = second_on_r;
  assign out_second_len = second_len_r;
  assign out_last       = last_r;

  // checks
  `IRFE_ASSERT_IMP(a_idx_in_frame, clk, rst_n, state_r == ST_SEND, sym_idx_r < frame_len_r)
  `IRFE_ASSERT_NXT(a_last_ends_frame, clk, rst_n, emit && sym_last, state_r == ST_IDLE && out_last)
  `IRFE_ASSERT_NXT(a_toggle_on_key, clk, rst_n, !in_acc, $stable(toggle_r) && $stable(prev_key_r))
  `IRFE_ASSERT_IMP(a_frame_len, clk, rst_n, state_r == ST_SEND && !is3010_r, frame_len_r == RC6_SYMS)

endmodule

>>> verif/ir_remote_frame_encoder_checker.sv
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_checker
// Watches the key, symbol and configuration ports of the IR frame encoder,
// predicts every RC-6 and 3010 symbol of each accepted key and compares the
// symbol transactions against them in order
// ----------------------------------------------------------------------------
module ir_remote_frame_encoder_checker
  import irfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // key channel
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [6:0]  in_key_index,
  // symbol channel
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_first_on,
  input  logic [7:0]  out_first_len,
  input  logic        out_second_on,
  input  logic [7:0]  out_second_len,
  input  logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  // status to the testbench top
  output int          pending_symbols,
  output int          error_count
);

  localparam int MAX_REPORTS = 40;

  // key code per key, key 1 first
  localparam logic [8*TABLE_FILL-1:0] KEY_CODES = {
    {15{8'hFF}}, 8'h0C,
    8'hFF, 8'h83, 8'h0C,
    8'hFF, 8'h0D, 8'hCC, 8'hF2,
    8'hFF, 8'h54, 8'h10, 8'h58, 8'h20,
    8'hFF, 8'h5A, 8'h5C, 8'h5B, 8'h11, 8'h59,
    8'hFF, 8'h21, 8'hA9, 8'h6D, 8'h6E, 8'h6F, 8'h70,
    8'hFF, 8'h4B, 8'hD8, 8'hF3, 8'h84, 8'h0F, 8'h29, 8'h30,
    8'hFF, 8'h28, 8'h37, 8'h2C, 8'h31, 8'h01, 8'h02, 8'h03, 8'h04,
    8'hFF, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h38, 8'h00, 8'hFB, 8'hFF
  };

  typedef struct packed {
    logic       first_on;
    logic [7:0] first_len;
    logic       second_on;
    logic [7:0] second_len;
    logic       last;
  } symbol_t;

  symbol_t    expected_symbols[$];
  int         fails = 0;

  // shadow of the configuration registers and frame state
  logic [3:0] mode_bits;
  logic [7:0] system_high;
  logic [7:0] system_low;
  logic [7:0] control_byte;
  logic [4:0] user_code;
  logic [6:0] prev_key;
  logic       toggle_bit;

  function automatic void push_symbol(input logic on1, input logic [7:0] len1,
                                      input logic on2, input logic [7:0] len2);
    symbol_t sym;
    sym.first_on   = on1;
    sym.first_len  = len1 & LEN_MASK;
    sym.second_on  = on2;
    sym.second_len = len2 & LEN_MASK;
    sym.last       = 1'b0;
    expected_symbols.push_back(sym);
  endfunction

  // rc-6 bit: 1 is on then off, 0 is off then on
  function automatic void push_rc6_bits(input logic [7:0] value, input int count);
    for (int i = count - 1; i >= 0; i--) begin
      push_symbol(value[i], RC6_UNIT, ~value[i], RC6_UNIT);
    end
  endfunction

  // 3010 bit: 1 is off then on, 0 is on then off
  function automatic void push_3010_bits(input logic [7:0] value, input int count);
    for (int i = count - 1; i >= 0; i--) begin
      push_symbol(~value[i], HALF_3010, value[i], HALF_3010);
    end
  endfunction

  // toggle and previous key update, then the whole frame of one key
  function automatic void predict_frame(input logic [6:0] key);
    logic [7:0] code;
    int         idx;
    symbol_t    tail;
    if (key == 7'd0) begin
      prev_key = 7'd0;
      return;
    end
    if (key != prev_key) begin
      toggle_bit = ~toggle_bit;
    end
    prev_key = key;
    idx = int'(key) - 1;
    if (idx >= TABLE_DEPTH || idx >= TABLE_FILL) begin
      code = NO_CODE;
    end else begin
      code = KEY_CODES[(TABLE_FILL - 1 - idx) * 8 +: 8];
    end
    if (code == NO_CODE) begin
      return;
    end
    if (key == KEY_3010_A || key == KEY_3010_B) begin
      push_3010_bits({2'b11, toggle_bit, user_code}, 8);
      push_3010_bits({2'b00, code[5:0]}, 6);
    end else begin
      push_symbol(1'b1, HEAD_ON_LEN, 1'b0, HEAD_OFF_LEN);
      push_rc6_bits({4'd0, mode_bits}, 4);
      push_symbol(toggle_bit, RC6_DOUBLE, ~toggle_bit, RC6_DOUBLE);
      push_rc6_bits(system_high, 8);
      push_rc6_bits(system_low, 8);
      push_rc6_bits(control_byte, 8);
      push_rc6_bits(code, 8);
    end
    // mark the frame end
    tail = expected_symbols.pop_back();
    tail.last = 1'b1;
    expected_symbols.push_back(tail);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (fails < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
      fails++;
    end
  endfunction

  function automatic void check_symbol();
    symbol_t want;
    if (expected_symbols.size() == 0) begin
      if (fails < MAX_REPORTS) begin
        $display("%0t: unexpected symbol, expected none, got on %0d/%0d len %0d/%0d last %0d",
                 $time, out_first_on, out_second_on, out_first_len, out_second_len, out_last);
      end
      fails++;
      return;
    end
    want = expected_symbols.pop_front();
    check_field("first_on", want.first_on, out_first_on);
    check_field("first_len", want.first_len, out_first_len);
    check_field("second_on", want.second_on, out_second_on);
    check_field("second_len", want.second_len, out_second_len);
    check_field("last", want.last, out_last);
  endfunction

  // monitor all three ports on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_bits    = 4'd6;
      system_high  = 8'h80;
      system_low   = 8'h56;
      control_byte = 8'hA7;
      user_code    = 5'd0;
      prev_key     = 7'd0;
      toggle_bit   = 1'b0;
      expected_symbols.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MODE_BITS:    mode_bits    = pwdata[3:0];
          REG_SYSTEM_HIGH:  system_high  = pwdata[7:0];
          REG_SYSTEM_LOW:   system_low   = pwdata[7:0];
          REG_CONTROL_BYTE: control_byte = pwdata[7:0];
          REG_USER_CODE:    user_code    = pwdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_symbol();
      end
      if (in_valid && !in_stall) begin
        predict_frame(in_key_index);
      end
    end
    pending_symbols <= expected_symbols.size();
    error_count     <= fails;
  end

endmodule

>>> verif/tb_ir_remote_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_ir_remote_frame_encoder_unit
// Drives keys and register writes into the IR frame encoder: a directed run
// of corner keys under reset settings, then random key streams under zero,
// maximum and random register settings, with random idle on both channels
// ----------------------------------------------------------------------------
module tb_ir_remote_frame_encoder_unit;
  import irfe_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int KEYS_PER_PHASE = 48;
  localparam int NUM_DIRECTED   = 24;
  localparam int NUM_USED       = 44;

  // corner keys: no key, all ones, unused, repeats, release and re-press,
  // both 3010 keys, table end and beyond the filled table
  localparam logic [7*NUM_DIRECTED-1:0] DIRECTED_KEYS = {
    7'd0, 7'd127, 7'd1, 7'd16, 7'd16, 7'd0, 7'd16, 7'd57, 7'd57, 7'd18,
    7'd19, 7'd67, 7'd66, 7'd68, 7'd69, 7'd92, 7'd22, 7'd44, 7'd23, 7'd2,
    7'd17, 7'd37, 7'd64, 7'd0
  };

  // keys that carry a code
  localparam logic [7*NUM_USED-1:0] USED_KEYS = {
    7'd16, 7'd18, 7'd19, 7'd21, 7'd22, 7'd23, 7'd25, 7'd26, 7'd27, 7'd28,
    7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40,
    7'd41, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd51, 7'd52,
    7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd60, 7'd61, 7'd62, 7'd63,
    7'd64, 7'd65, 7'd66, 7'd67
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [6:0]  in_key_index;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_first_on;
  logic [7:0]  out_first_len;
  logic        out_second_on;
  logic [7:0]  out_second_len;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        no_idle = 1'b0;
  int          stall_cnt = 0;
  int          pending_symbols;
  int          error_count;

  ir_remote_frame_encoder_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_index   (in_key_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first_on   (out_first_on),
    .out_first_len  (out_first_len),
    .out_second_on  (out_second_on),
    .out_second_len (out_second_len),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ir_remote_frame_encoder_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key_index    (in_key_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_on    (out_first_on),
    .out_first_len   (out_first_len),
    .out_second_on   (out_second_on),
    .out_second_len  (out_second_len),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pending_symbols (pending_symbols),
    .error_count     (error_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // symbol sink: random stall after each symbol transaction
  always @(posedge clk) begin : symbol_sink
    int gap;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else if (out_valid && !out_stall) begin
      gap = draw_wait();
      out_stall <= (gap != 0);
      stall_cnt <= gap;
    end else if (stall_cnt > 1) begin
      stall_cnt <= stall_cnt - 1;
    end else begin
      stall_cnt <= 0;
      out_stall <= 1'b0;
    end
  end

  // mostly coded keys, some repeats, releases and arbitrary noise
  function automatic logic [6:0] pick_key(input logic [6:0] last_key);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return USED_KEYS[$urandom_range(0, NUM_USED - 1) * 7 +: 7];
    end else if (sel < 60) begin
      return ($urandom_range(0, 1) != 0) ? KEY_3010_A : KEY_3010_B;
    end else if (sel < 75) begin
      return last_key;
    end else if (sel < 85) begin
      return 7'd0;
    end
    return 7'($urandom_range(0, 127));
  endfunction

  // one key transaction, returns right after the accepting edge
  task automatic send_key(input logic [6:0] key);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_index <= key;
    do @(posedge clk); while (in_stall);
  endtask

  // setup and access cycle, psel stays high for a following write
  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_regs(input logic [3:0] mode, input logic [7:0] sys_hi,
                            input logic [7:0] sys_lo, input logic [7:0] ctrl,
                            input logic [4:0] user);
    apb_write(REG_MODE_BITS, {28'd0, mode});
    apb_write(REG_SYSTEM_HIGH, {24'd0, sys_hi});
    apb_write(REG_SYSTEM_LOW, {24'd0, sys_lo});
    apb_write(REG_CONTROL_BYTE, {24'd0, ctrl});
    apb_write(REG_USER_CODE, {27'd0, user});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and let the block drain
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_symbols != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [6:0] last_key;
    in_valid     = 1'b0;
    in_key_index = 7'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = 5'd0;
    pwdata       = 32'd0;
    rst_n        = 1'b0;
    last_key     = 7'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner keys under reset settings
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_key(DIRECTED_KEYS[(NUM_DIRECTED - 1 - i) * 7 +: 7]);
    end
    drain();

    // random keys, settings change between phases
    for (int phase = 1; phase < NUM_PHASES; phase++) begin
      if (phase == 1) begin
        write_regs(4'd0, 8'd0, 8'd0, 8'd0, 5'd0);
      end else if (phase == 2) begin
        write_regs(4'd15, 8'd255, 8'd255, 8'd255, 5'd31);
      end else begin
        write_regs(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   5'($urandom_range(0, 31)));
      end
      for (int k = 0; k < KEYS_PER_PHASE; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          no_idle <= ~no_idle;
        end
        last_key = pick_key(last_key);
        send_key(last_key);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/irfe_pkg.sv
rtl/ir_remote_frame_encoder_unit.sv
verif/ir_remote_frame_encoder_checker.sv
verif/tb_ir_remote_frame_encoder_unit.sv
